@@ hdl/cis_pkg.sv @@
`default_nettype none

package cis_pkg;

    // map limits
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    // circle samples and table
    localparam int SAMPLES = 126;
    localparam int K_W     = 7;
    localparam int TRIG_W  = 16;

    // field widths
    localparam int PIX_W   = 9;
    localparam int DIST_W  = 10;
    localparam int CEN_W   = 20;
    localparam int RAD_W   = 19;
    localparam int CNT_W   = 7;
    localparam int CFG_W   = 10;
    localparam int CFGI_W  = 2;
    localparam int COORD_W = 19;

    // shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;

    // rotation step, cos 0.05 and sin 0.05 in q2.30
    localparam logic signed [MUL_W-1:0] STEP_COS = 32'sd1072399926;
    localparam logic signed [MUL_W-1:0] STEP_SIN = 32'sd53664724;
    localparam logic signed [MUL_W-1:0] Q30_ONE  = 32'sd1073741824;

    // distance threshold bands
    localparam logic [RAD_W-1:0]  R_SMALL_MAX = 19'd800;
    localparam logic [RAD_W-1:0]  R_BIG_MIN   = 19'd40000;
    localparam logic [DIST_W-1:0] D_SMALL     = 10'd2;
    localparam logic [DIST_W-1:0] D_BIG       = 10'd100;
    localparam logic [RAD_W-1:0]  DIST_SCALE  = 19'd400;

    // register indexes
    localparam logic [CFGI_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_MAP_HEIGHT = 2'd1;

    // item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_q;
        logic signed [TRIG_W-1:0] sin_q;
    } trig_word_t;

    // round half up from q?.60 to q2.30
    function automatic logic signed [MUL_W-1:0] round_q30(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v + 64'sd536870912;
        return t[61:30];
    endfunction

    // q2.30 to q1.15, round half up, saturate
    function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [MUL_W-1:0] v);
        logic signed [MUL_W:0] t;
        logic signed [17:0]    r;
        t = {v[MUL_W-1], v} + 33'sd16384;
        r = t[32:15];
        if (r > 18'sd32767)
            return 16'sh7fff;
        else if (r < -18'sd32768)
            return 16'sh8000;
        else
            return r[15:0];
    endfunction

    // floor of (radius*trig + centre<<15) / 2^19
    function automatic logic signed [COORD_W-1:0] coord(
        input logic signed [PROD_W-1:0] p,
        input logic signed [CEN_W-1:0]  cen
    );
        logic signed [37:0] sum;
        sum = p[37:0] + {{3{cen[CEN_W-1]}}, cen, 15'd0};
        return sum[37:19];
    endfunction

endpackage

`default_nettype wire

@@ hdl/cis_mul.sv @@
`default_nettype none

module cis_mul (
    input  wire                               clk,
    input  wire  signed [cis_pkg::MUL_W-1:0]  a,
    input  wire  signed [cis_pkg::MUL_W-1:0]  b,
    output logic signed [cis_pkg::PROD_W-1:0] p_reg
);
    import cis_pkg::*;

    // registered signed product
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

`default_nettype wire

@@ hdl/cis_trig_mem.sv @@
`default_nettype none

module cis_trig_mem (
    input  wire                       clk,
    input  wire                       we,
    input  wire  [cis_pkg::K_W-1:0]   waddr,
    input  wire  cis_pkg::trig_word_t wdata,
    input  wire                       re,
    input  wire  [cis_pkg::K_W-1:0]   raddr,
    output cis_pkg::trig_word_t       rdata_reg
);
    import cis_pkg::*;

    trig_word_t mem [SAMPLES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/cis_map_mem.sv @@
`default_nettype none

module cis_map_mem #(
    parameter int MAX_WIDTH  = cis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cis_pkg::DEF_MAX_HEIGHT,
    parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  wire                          clk,
    input  wire                          we,
    input  wire  [AW-1:0]                waddr,
    input  wire  [cis_pkg::DIST_W-1:0]   wdata,
    input  wire                          re,
    input  wire  [AW-1:0]                raddr,
    output logic [cis_pkg::DIST_W-1:0]   rdata_reg
);
    import cis_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [DIST_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/circle_inlier_score_core.sv @@
`default_nettype none

// channel   signals                                        direction
// ------------------------------------------------------------------
// in        in_valid, in_ready, action, pixel_x, pixel_y,  sink
//           distance, center_x, center_y, radius
// out       out_valid, out_ready, inlier_count             source
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data      sink
//
// after reset the sine/cosine table is built on the shared multiplier, one entry
// per rotation step, with in_ready low throughout
// a write beat goes to the map as it is taken and the block stays idle; an evaluate
// beat walks each sample through table read, two products, map read and compare
// in turn on the one multiplier and the one map read port; an evaluate stalls
// at its last sample while the previous result waits; cfg_ready is always high

module circle_inlier_score_core #(
    parameter int MAX_WIDTH  = cis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cis_pkg::DEF_MAX_HEIGHT
) (
    input  wire                                clk,
    input  wire                                rst_n,

    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                action,
    input  wire         [cis_pkg::PIX_W-1:0]   pixel_x,
    input  wire         [cis_pkg::PIX_W-1:0]   pixel_y,
    input  wire         [cis_pkg::DIST_W-1:0]  distance,
    input  wire  signed [cis_pkg::CEN_W-1:0]   center_x,
    input  wire  signed [cis_pkg::CEN_W-1:0]   center_y,
    input  wire         [cis_pkg::RAD_W-1:0]   radius,

    output logic                               out_valid,
    input  wire                                out_ready,
    output logic        [cis_pkg::CNT_W-1:0]   inlier_count,

    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire         [cis_pkg::CFGI_W-1:0]  cfg_index,
    input  wire         [cis_pkg::CFG_W-1:0]   cfg_data
);
    import cis_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    // one-hot sequencer
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_B_WR  = 11'b000_0000_0010,   // table build: store entry, c*cos
        ST_B_M1  = 11'b000_0000_0100,   // s*sin
        ST_B_M2  = 11'b000_0000_1000,   // s*cos, new c
        ST_B_M3  = 11'b000_0001_0000,   // c*sin
        ST_B_M4  = 11'b000_0010_0000,   // new s
        ST_E_RD  = 11'b000_0100_0000,   // evaluate: table read
        ST_E_MX  = 11'b000_1000_0000,   // r*cos
        ST_E_MY  = 11'b001_0000_0000,   // r*sin, x
        ST_E_AD  = 11'b010_0000_0000,   // y, bounds, map read
        ST_E_CMP = 11'b100_0000_0000    // compare and count
    } state_t;

    state_t state_reg, state_next;

    logic        [K_W-1:0]    k_reg, k_next;
    logic signed [MUL_W-1:0]  c_reg, c_next;
    logic signed [MUL_W-1:0]  s_reg, s_next;
    logic signed [MUL_W-1:0]  nc_reg, nc_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic        [CNT_W-1:0]  cnt_reg, cnt_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic                     inside_reg, inside_next;
    logic signed [CEN_W-1:0]  cx_reg, cx_next;
    logic signed [CEN_W-1:0]  cy_reg, cy_next;
    logic        [RAD_W-1:0]  r_reg, r_next;
    logic                     r_small_reg, r_small_next;
    logic                     r_big_reg, r_big_next;
    logic        [CFG_W-1:0]  map_width_reg, map_width_next;
    logic        [CFG_W-1:0]  map_height_reg, map_height_next;
    logic                     out_valid_reg, out_valid_next;
    logic        [CNT_W-1:0]  inlier_count_reg, inlier_count_next;

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    // table and map ports
    logic                     trig_we, trig_re;
    trig_word_t               trig_wdata, trig_q;
    logic                     map_we, map_re;
    logic        [AW-1:0]     map_waddr, map_raddr;
    logic        [DIST_W-1:0] map_q;

    logic                     in_acc, done_ok, last_k;
    logic signed [COORD_W-1:0] y_now;
    logic                     x_ok, y_ok, hit;
    logic        [RAD_W-1:0]  d_scaled;

    cis_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    cis_trig_mem u_trig (
        .clk       (clk),
        .we        (trig_we),
        .waddr     (k_reg),
        .wdata     (trig_wdata),
        .re        (trig_re),
        .raddr     (k_reg),
        .rdata_reg (trig_q)
    );

    cis_map_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_map (
        .clk       (clk),
        .we        (map_we),
        .waddr     (map_waddr),
        .wdata     (distance),
        .re        (map_re),
        .raddr     (map_raddr),
        .rdata_reg (map_q)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign inlier_count = inlier_count_reg;

    assign in_acc  = in_valid && in_ready;
    assign last_k  = (k_reg == K_W'(SAMPLES - 1));
    assign done_ok = !out_valid_reg || out_ready;

    // table entry from the current rotation vector
    assign trig_wdata.cos_q = to_q15(c_reg);
    assign trig_wdata.sin_q = to_q15(s_reg);
    assign trig_we          = (state_reg == ST_B_WR);
    assign trig_re          = (state_reg == ST_E_RD);

    // map write straight from the accepted beat, dropped when off the map
    assign map_we    = in_acc && (action == ACT_WRITE)
                       && ({23'd0, pixel_x} < 32'(MAX_WIDTH))
                       && ({23'd0, pixel_y} < 32'(MAX_HEIGHT));
    assign map_waddr = AW'(pixel_y) * AW'(MAX_WIDTH) + AW'(pixel_x);

    // y from the second product, bounds on both coordinates
    assign y_now = coord(mul_p, cy_reg);
    assign x_ok  = !x_reg[COORD_W-1]
                   && (x_reg[COORD_W-2:0] < {8'd0, map_width_reg})
                   && ({14'd0, x_reg[COORD_W-2:0]} < 32'(MAX_WIDTH));
    assign y_ok  = !y_now[COORD_W-1]
                   && (y_now[COORD_W-2:0] < {8'd0, map_height_reg})
                   && ({14'd0, y_now[COORD_W-2:0]} < 32'(MAX_HEIGHT));

    assign map_re    = (state_reg == ST_E_AD);
    assign map_raddr = AW'(y_now[COORD_W-2:0]) * AW'(MAX_WIDTH) + AW'(x_reg[COORD_W-2:0]);

    // threshold: fixed bands at the ends, distance*400 < radius between
    assign d_scaled = RAD_W'(map_q) * DIST_SCALE;

    always_comb
    begin
        priority if (r_small_reg)
            hit = (map_q < D_SMALL);
        else if (r_big_reg)
            hit = (map_q < D_BIG);
        else
            hit = (d_scaled < r_reg);
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = c_reg;
        mul_b = STEP_COS;
        unique case (state_reg)
            ST_B_M1:
            begin
                mul_a = s_reg;
                mul_b = STEP_SIN;
            end
            ST_B_M2:
            begin
                mul_a = s_reg;
                mul_b = STEP_COS;
            end
            ST_B_M3:
            begin
                mul_a = c_reg;
                mul_b = STEP_SIN;
            end
            ST_E_MX:
            begin
                mul_a = {13'd0, r_reg};
                mul_b = MUL_W'(trig_q.cos_q);
            end
            ST_E_MY:
            begin
                mul_a = {13'd0, r_reg};
                mul_b = MUL_W'(trig_q.sin_q);
            end
            default:
            begin
                mul_a = c_reg;
                mul_b = STEP_COS;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        k_next            = k_reg;
        c_next            = c_reg;
        s_next            = s_reg;
        nc_next           = nc_reg;
        acc_next          = acc_reg;
        cnt_next          = cnt_reg;
        x_next            = x_reg;
        inside_next       = inside_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        r_next            = r_reg;
        r_small_next      = r_small_reg;
        r_big_next        = r_big_reg;
        map_width_next    = map_width_reg;
        map_height_next   = map_height_reg;
        out_valid_next    = out_valid_reg;
        inlier_count_next = inlier_count_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MAP_WIDTH)
                map_width_next = cfg_data;
            else if (cfg_index == CFG_MAP_HEIGHT)
                map_height_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (action == ACT_EVAL))
                begin
                    cx_next      = center_x;
                    cy_next      = center_y;
                    r_next       = radius;
                    r_small_next = (radius <= R_SMALL_MAX);
                    r_big_next   = (radius >= R_BIG_MIN);
                    k_next       = '0;
                    cnt_next     = '0;
                    state_next   = ST_E_RD;
                end
            end
            ST_B_WR:
            begin
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_B_M1;
                end
            end
            ST_B_M1:
            begin
                acc_next   = mul_p;
                state_next = ST_B_M2;
            end
            ST_B_M2:
            begin
                nc_next    = round_q30(acc_reg - mul_p);
                state_next = ST_B_M3;
            end
            ST_B_M3:
            begin
                acc_next   = mul_p;
                state_next = ST_B_M4;
            end
            ST_B_M4:
            begin
                s_next     = round_q30(acc_reg + mul_p);
                c_next     = nc_reg;
                k_next     = k_reg + 1'b1;
                state_next = ST_B_WR;
            end
            ST_E_RD:
            begin
                state_next = ST_E_MX;
            end
            ST_E_MX:
            begin
                state_next = ST_E_MY;
            end
            ST_E_MY:
            begin
                x_next     = coord(mul_p, cx_reg);
                state_next = ST_E_AD;
            end
            ST_E_AD:
            begin
                inside_next = x_ok && y_ok;
                state_next  = ST_E_CMP;
            end
            ST_E_CMP:
            begin
                // the last sample holds here until the output register is free
                if (!last_k)
                begin
                    if (inside_reg && hit)
                        cnt_next = cnt_reg + 1'b1;
                    k_next     = k_reg + 1'b1;
                    state_next = ST_E_RD;
                end
                else if (done_ok)
                begin
                    inlier_count_next = cnt_reg + CNT_W'(inside_reg && hit);
                    out_valid_next    = 1'b1;
                    k_next            = '0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_B_WR;
            k_reg          <= '0;
            c_reg          <= Q30_ONE;
            s_reg          <= '0;
            cnt_reg        <= '0;
            map_width_reg  <= CFG_W'(512);
            map_height_reg <= CFG_W'(512);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            c_reg          <= c_next;
            s_reg          <= s_next;
            cnt_reg        <= cnt_next;
            map_width_reg  <= map_width_next;
            map_height_reg <= map_height_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        nc_reg           <= nc_next;
        acc_reg          <= acc_next;
        x_reg            <= x_next;
        inside_reg       <= inside_next;
        cx_reg           <= cx_next;
        cy_reg           <= cy_next;
        r_reg            <= r_next;
        r_small_reg      <= r_small_next;
        r_big_reg        <= r_big_next;
        inlier_count_reg <= inlier_count_next;
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import cis_pkg::*;

    // map geometry as built into the block
    localparam int MAP_COLS  = DEF_MAX_WIDTH;
    localparam int MAP_ROWS  = DEF_MAX_HEIGHT;
    localparam int MAP_CELLS = MAP_COLS * MAP_ROWS;

    // rotation step of the trig table, q2.30
    localparam longint ROT_COS = 64'sd1072399926;
    localparam longint ROT_SIN = 64'sd53664724;

    // inlier threshold bands on the raw q4 radius
    localparam longint NEAR_R_MAX    = 800;
    localparam longint FAR_R_MIN     = 40000;
    localparam longint NEAR_DIST     = 2;
    localparam longint FAR_DIST      = 100;
    localparam longint DIST_PER_UNIT = 400;

    // field extremes
    localparam longint CEN_MIN = -524288;
    localparam longint CEN_MAX = 524287;
    localparam longint RAD_MAX = 524287;

    // register indexes the block does not decode
    localparam logic [CFGI_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_SPARE_HI = 2'd3;

    // long enough for an evaluate beat to walk its 126 samples, plus margin
    localparam int DRAIN_CYCLES = 700;
    // side length of the corner boxes that random circles gather in
    localparam int ZONE_SPAN    = 40;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic                     act;
        logic        [PIX_W-1:0]  px;
        logic        [PIX_W-1:0]  py;
        logic        [DIST_W-1:0] dval;
        logic signed [CEN_W-1:0]  cx;
        logic signed [CEN_W-1:0]  cy;
        logic        [RAD_W-1:0]  rad;
    } circle_item_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      in_valid     = 1'b0;
    logic                      in_ready;
    logic                      action       = ACT_WRITE;
    logic        [PIX_W-1:0]   pixel_x      = '0;
    logic        [PIX_W-1:0]   pixel_y      = '0;
    logic        [DIST_W-1:0]  distance     = '0;
    logic signed [CEN_W-1:0]   center_x     = '0;
    logic signed [CEN_W-1:0]   center_y     = '0;
    logic        [RAD_W-1:0]   radius       = '0;
    logic                      out_valid;
    logic                      out_ready    = 1'b0;
    logic        [CNT_W-1:0]   inlier_count;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic        [CFGI_W-1:0]  cfg_index    = '0;
    logic        [CFG_W-1:0]   cfg_data     = '0;

    // predictor state: map contents, which cells hold a value, registers
    logic [DIST_W-1:0] edge_dist [MAP_CELLS];
    bit                dist_known [MAP_CELLS];
    logic [CFG_W-1:0]  map_cols_reg = CFG_W'(MAP_COLS);
    logic [CFG_W-1:0]  map_rows_reg = CFG_W'(MAP_ROWS);
    longint            cos_q15 [SAMPLES];
    longint            sin_q15 [SAMPLES];

    // inlier counts still owed by the block, oldest first
    logic [CNT_W-1:0]  expected_counts [$];

    int items_sent   = 0;
    int fault_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    logic rx_hold    = 1'b0;

    circle_inlier_score_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .distance     (distance),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .inlier_count (inlier_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // round half up of a q2.30 product sum down to q2.30
    function automatic longint half_up_q30(input longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // q2.30 to q1.15, round half up, saturate
    function automatic longint q30_to_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    // table of sample directions, built by repeated rotation of (1, 0)
    function automatic void build_trig();
        longint c;
        longint s;
        longint nc;
        longint ns;
        int     k;
        c = 64'sd1 <<< 30;
        s = 0;
        for (k = 0; k < SAMPLES; k++)
        begin
            cos_q15[k] = q30_to_q15(c);
            sin_q15[k] = q30_to_q15(s);
            nc = half_up_q30(c * ROT_COS - s * ROT_SIN);
            ns = half_up_q30(s * ROT_COS + c * ROT_SIN);
            c  = nc;
            s  = ns;
        end
    endfunction

    function automatic int used_cols();
        return (map_cols_reg > MAP_COLS) ? MAP_COLS : int'(map_cols_reg);
    endfunction

    function automatic int used_rows();
        return (map_rows_reg > MAP_ROWS) ? MAP_ROWS : int'(map_rows_reg);
    endfunction

    function automatic int cell_of(input longint x, input longint y);
        return int'(y) * MAP_COLS + int'(x);
    endfunction

    // floored map position of sample k: centre plus radius times direction
    function automatic void sample_point(input circle_item_t it, input int k,
                                         output longint x, output longint y);
        longint rr;
        longint cxl;
        longint cyl;
        rr  = it.rad;
        cxl = it.cx;
        cyl = it.cy;
        x = (rr * cos_q15[k] + (cxl <<< 15)) >>> 19;
        y = (rr * sin_q15[k] + (cyl <<< 15)) >>> 19;
    endfunction

    function automatic bit point_in_map(input longint x, input longint y);
        return x >= 0 && x < used_cols() && y >= 0 && y < used_rows();
    endfunction

    // number of samples that land on a cell close enough to an edge
    function automatic int score_circle(input circle_item_t it);
        longint x;
        longint y;
        longint rr;
        longint d;
        int     k;
        int     hits;
        bit     near;
        rr   = it.rad;
        hits = 0;
        for (k = 0; k < SAMPLES; k++)
        begin
            sample_point(it, k, x, y);
            if (point_in_map(x, y))
            begin
                d = edge_dist[cell_of(x, y)];
                // threshold is radius/25 clamped to [2, 100], kept exact
                if (rr <= NEAR_R_MAX)
                    near = d < NEAR_DIST;
                else if (rr >= FAR_R_MIN)
                    near = d < FAR_DIST;
                else
                    near = d * DIST_PER_UNIT < rr;
                if (near)
                    hits++;
            end
        end
        return hits;
    endfunction

    // called at the edge where a beat is taken, so the map stays in step
    function automatic void apply_item(input circle_item_t it);
        if (it.act == ACT_WRITE)
        begin
            if (it.px < MAP_COLS && it.py < MAP_ROWS)
            begin
                edge_dist[cell_of(it.px, it.py)]  = it.dval;
                dist_known[cell_of(it.px, it.py)] = 1'b1;
            end
        end
        else
            expected_counts = {expected_counts, CNT_W'(score_circle(it))};
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic void report_fault(input string what, input int want, input int got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    // receiver: random stalls, or held off completely by hold_receiver
    always @(posedge clk)
        out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);

    // every result beat is matched against the oldest owed count
    always @(posedge clk)
    begin : check_counts
        logic [CNT_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_counts.size() == 0)
                report_fault("result beat with nothing owed", -1, int'(inlier_count));
            else
            begin
                want = expected_counts.pop_front();
                if (inlier_count !== want)
                    report_fault("inlier_count", int'(want), int'(inlier_count));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // every field random, so the ignored fields toggle too
    function automatic circle_item_t noise_item();
        circle_item_t it;
        it.act  = 1'($urandom);
        it.px   = PIX_W'($urandom);
        it.py   = PIX_W'($urandom);
        it.dval = DIST_W'($urandom);
        it.cx   = CEN_W'($urandom);
        it.cy   = CEN_W'($urandom);
        it.rad  = RAD_W'($urandom);
        return it;
    endfunction

    // distances weighted towards the narrow threshold bands
    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(9))
            0, 1, 2, 3: return DIST_W'($urandom_range(3));
            4, 5, 6:    return DIST_W'($urandom_range(127));
            7, 8:       return DIST_W'($urandom_range(1023));
            default:    return ($urandom_range(1) == 0) ? '0 : '1;
        endcase
    endfunction

    // coordinate in one of the boxes at either end of the used range
    function automatic int zone_coord(input int used);
        int span;
        if (used == 0)
            return $urandom_range(MAP_COLS - 1);
        span = (used < ZONE_SPAN) ? used : ZONE_SPAN;
        if ($urandom_range(1) == 0)
            return $urandom_range(span - 1);
        return used - 1 - $urandom_range(span - 1);
    endfunction

    function automatic longint clamp_centre(input longint c);
        if (c > CEN_MAX)
            return CEN_MAX;
        if (c < CEN_MIN)
            return CEN_MIN;
        return c;
    endfunction

    // random circle; mostly placed so that one chosen sample hits the map
    function automatic circle_item_t pick_circle();
        circle_item_t it;
        longint       r;
        longint       ax;
        longint       ay;
        int           k;
        it     = noise_item();
        it.act = ACT_EVAL;
        case ($urandom_range(9))
            0, 1, 2, 3: r = ($urandom_range(3) == 0) ? $urandom_range(NEAR_R_MAX)
                                                     : $urandom_range(160);
            4, 5, 6:    r = $urandom_range(FAR_R_MIN - 1, NEAR_R_MAX + 1);
            7, 8:       r = $urandom_range(RAD_MAX, FAR_R_MIN);
            default:
                case ($urandom_range(5))
                    0:       r = 0;
                    1:       r = NEAR_R_MAX;
                    2:       r = NEAR_R_MAX + 1;
                    3:       r = FAR_R_MIN - 1;
                    4:       r = FAR_R_MIN;
                    default: r = RAD_MAX;
                endcase
        endcase
        it.rad = RAD_W'(r);
        if ($urandom_range(4) != 0)
        begin
            ax = zone_coord(used_cols());
            ay = zone_coord(used_rows());
            k  = $urandom_range(SAMPLES - 1);
            it.cx = CEN_W'(clamp_centre(ax * 16 + longint'($urandom_range(15))
                                        - ((r * cos_q15[k]) >>> 15)));
            it.cy = CEN_W'(clamp_centre(ay * 16 + longint'($urandom_range(15))
                                        - ((r * sin_q15[k]) >>> 15)));
        end
        return it;
    endfunction

    // one beat on the item channel; valid stays up between back-to-back beats
    task automatic send_item(input circle_item_t it);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        action   <= it.act;
        pixel_x  <= it.px;
        pixel_y  <= it.py;
        distance <= it.dval;
        center_x <= it.cx;
        center_y <= it.cy;
        radius   <= it.rad;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        items_sent++;
        apply_item(it);
    endtask

    task automatic write_cell(input int x, input int y, input logic [DIST_W-1:0] d);
        circle_item_t it;
        it      = noise_item();
        it.act  = ACT_WRITE;
        it.px   = PIX_W'(x);
        it.py   = PIX_W'(y);
        it.dval = d;
        send_item(it);
    endtask

    // the map holds nothing until written, so every cell a circle will
    // read gets a value first
    task automatic evaluate(input circle_item_t it);
        longint x;
        longint y;
        int     k;
        for (k = 0; k < SAMPLES; k++)
        begin
            sample_point(it, k, x, y);
            if (point_in_map(x, y) && !dist_known[cell_of(x, y)])
                write_cell(int'(x), int'(y), pick_distance());
        end
        send_item(it);
    endtask

    task automatic eval_at(input longint cx, input longint cy, input longint r);
        circle_item_t it;
        it     = noise_item();
        it.act = ACT_EVAL;
        it.cx  = CEN_W'(cx);
        it.cy  = CEN_W'(cy);
        it.rad = RAD_W'(r);
        evaluate(it);
    endtask

    task automatic send_random_write();
        if ($urandom_range(9) < 7)
            write_cell(zone_coord(used_cols()), zone_coord(used_rows()), pick_distance());
        else
            write_cell($urandom_range(MAP_COLS - 1), $urandom_range(MAP_ROWS - 1),
                       pick_distance());
    endtask

    task automatic wait_drained();
        while (expected_counts.size() != 0)
            @(posedge clk);
    endtask

    // block idle: no beat offered, nothing owed, and a trailing write done
    task automatic wait_idle();
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // cfg_valid is left high so consecutive writes need no dip
    task automatic write_register(input logic [CFGI_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == CFG_MAP_WIDTH)
            map_cols_reg = value;
        else if (idx == CFG_MAP_HEIGHT)
            map_rows_reg = value;
    endtask

    task automatic set_map_size(input int cols, input int rows);
        wait_idle();
        write_register(CFG_MAP_WIDTH, CFG_W'(cols));
        write_register(CFG_MAP_HEIGHT, CFG_W'(rows));
        cfg_valid <= 1'b0;
    endtask

    // receiver held off for a counted stretch, in a process of its own
    task automatic hold_receiver(input int cycles);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (cycles) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // corner cells, distance and centre extremes, threshold band edges
    task automatic test_field_extremes();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_cell(0, 0, '0);
        write_cell(MAP_COLS - 1, MAP_ROWS - 1, DIST_W'(1));
        write_cell(MAP_COLS - 1, 0, '1);
        write_cell(0, MAP_ROWS - 1, DIST_W'(2));
        // zero radius: every sample on the centre cell
        eval_at(0, 0, 0);
        eval_at((MAP_COLS - 1) * 16 + 15, (MAP_ROWS - 1) * 16 + 15, 0);
        eval_at((MAP_COLS - 1) * 16, 0, 0);
        // distance two just misses the narrowest band
        eval_at(0, (MAP_ROWS - 1) * 16, 0);
        // a fraction below zero floors to -1, outside
        eval_at(-1, -1, 0);
        eval_at(MAP_COLS * 16, 0, 0);
        eval_at(CEN_MIN, CEN_MAX, 0);
        // band edges; the circle just grazes the origin from the left
        eval_at(8 - NEAR_R_MAX, 0, NEAR_R_MAX);
        eval_at(8 - NEAR_R_MAX - 1, 0, NEAR_R_MAX + 1);
        eval_at(8 - FAR_R_MIN + 1, 0, FAR_R_MIN - 1);
        eval_at(8 - FAR_R_MIN, 0, FAR_R_MIN);
        // largest radius with far centres
        eval_at(CEN_MIN, CEN_MIN, RAD_MAX);
        eval_at(CEN_MAX, CEN_MAX, RAD_MAX);
        eval_at(CEN_MAX, 0, RAD_MAX);
    endtask

    // undecoded indexes, oversize, zero and single-cell maps
    task automatic test_config_corners();
        wait_idle();
        write_register(CFG_SPARE_LO, CFG_W'($urandom));
        write_register(CFG_SPARE_HI, CFG_W'($urandom));
        cfg_valid <= 1'b0;
        eval_at((MAP_COLS - 1) * 16, (MAP_ROWS - 1) * 16, 0);
        // above the maximum saturates to the full map
        set_map_size(1023, 1023);
        eval_at((MAP_COLS - 1) * 16, (MAP_ROWS - 1) * 16, 0);
        set_map_size(0, MAP_ROWS);
        eval_at(0, 0, 0);
        set_map_size(MAP_COLS, 0);
        eval_at(0, 0, 0);
        set_map_size(1, 1);
        eval_at(0, 0, 0);
        eval_at((MAP_COLS - 1) * 16, 0, 0);
    endtask

    task automatic test_random_traffic(input int cols, input int rows, input int tx_idle,
                                       input int rx_stall, input int count);
        int stop_at;
        set_map_size(cols, rows);
        tx_idle_pct  = tx_idle;
        rx_stall_pct = rx_stall;
        stop_at      = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 40)
                evaluate(pick_circle());
            else
                send_random_write();
        end
    endtask

    // a result held by a stalled receiver blocks the next evaluate, so the input stalls;
    // then the sender waits for every owed result before going on
    task automatic test_backpressure();
        int i;
        set_map_size(64, 64);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_receiver(3000);
        for (i = 0; i < 6; i++)
        begin
            evaluate(pick_circle());
            send_random_write();
        end
        wait_idle();
        rx_stall_pct = 50;
        for (i = 0; i < 8; i++)
            evaluate(pick_circle());
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial
    begin
        build_trig();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_config_corners();
        test_random_traffic(512, 512, 0, 0, 200);
        test_random_traffic(16, 16, 80, 0, 150);
        test_random_traffic(1, 1, 0, 80, 60);
        test_random_traffic(1023, 40, 25, 25, 150);
        test_random_traffic(40, 1023, 0, 0, 120);
        test_random_traffic(0, 512, 25, 25, 40);
        test_random_traffic(512, 0, 80, 0, 40);
        test_random_traffic($urandom_range(64, 1), $urandom_range(64, 1), 0, 80, 150);
        test_random_traffic(512, 1, 80, 0, 80);
        test_random_traffic(1, 512, 0, 80, 80);
        test_backpressure();
        test_random_traffic(512, 512, 25, 25, 200);

        wait_idle();
        if (fault_count == 0 && expected_counts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #80_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
hdl/cis_pkg.sv
hdl/cis_mul.sv
hdl/cis_trig_mem.sv
hdl/cis_map_mem.sv
hdl/circle_inlier_score_core.sv
tb/testbench.sv
